@@ hw/rtl/scai_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scai_pkg: shared types and constants of the curve area integrator
// Operation beats passed from the point classifier to the term datapath,
// result beats, rule codes and datapath widths.
// ----------------------------------------------------------------------------
package scai_pkg;

  // Widest coordinate carried inside the datapath
  localparam int COORD_MAX_W = 32;
  // Width of an abscissa difference
  localparam int DX_W        = COORD_MAX_W + 1;
  // Width of the weighted ordinate sum y0 + 4*y1 + y2
  localparam int FAC_W       = COORD_MAX_W + 3;
  localparam int AREA_W      = 64;

  // Integration rule codes; the unused code acts as Simpson
  localparam logic [1:0] MODE_RECT  = 2'd0;
  localparam logic [1:0] MODE_TRAP  = 2'd1;
  localparam logic [1:0] MODE_SIMP  = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [1:0] RULE_RESET = MODE_TRAP;

  // How the raw product turns into a term
  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_HALF,
    KIND_SIXTH
  } kind_t;

  // One term to evaluate; a zero width gives a zero term
  typedef struct packed {
    logic signed [DX_W-1:0]  dx;
    logic signed [FAC_W-1:0] fac;
    kind_t                   kind;
    logic                    last;
  } op_t;

  // One finished curve
  typedef struct packed {
    logic signed [AREA_W-1:0] area;
    logic                     saturated;
  } result_t;

endpackage
`default_nettype wire

@@ hw/rtl/scai_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scai_fifo: small register queue
// First-word-fall-through queue in flops; a push while full is ignored.
// ----------------------------------------------------------------------------
module scai_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/scai_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scai_front: point classifier
// Holds the rule register and the last points, decides which term each
// point opens and forms its width and weighted ordinate sum.
// ----------------------------------------------------------------------------
module scai_front #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        rule_we,
  input  wire logic [1:0]  rule_wdata,
  input  wire logic        in_valid,
  input  wire logic [31:0] x_coord,
  input  wire logic [31:0] y_value,
  input  wire logic        last_point,
  input  wire logic        q_full,
  output logic             q_push,
  output scai_pkg::op_t    q_op
);

  import scai_pkg::*;

  localparam int SH = COORD_MAX_W - COORD_WIDTH;

  // Where the open curve stands
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ANCHOR,
    PH_MID
  } phase_t;

  logic [1:0]                    rule_mode;
  phase_t                        phase;
  phase_t                        phase_next;
  logic signed [COORD_MAX_W-1:0] prev_x;
  logic signed [COORD_MAX_W-1:0] prev_y;
  logic signed [COORD_MAX_W-1:0] anchor_x;
  logic signed [COORD_MAX_W-1:0] anchor_y;
  logic signed [COORD_MAX_W-1:0] x_sh;
  logic signed [COORD_MAX_W-1:0] y_sh;
  logic signed [COORD_MAX_W-1:0] x_ext;
  logic signed [COORD_MAX_W-1:0] y_ext;
  logic signed [DX_W-1:0]        dx_prev;
  logic signed [DX_W-1:0]        dx_anchor;
  logic signed [FAC_W-1:0]       y_w;
  logic signed [FAC_W-1:0]       prev_y_w;
  logic signed [FAC_W-1:0]       anchor_y_w;
  logic                          set_anchor;
  logic                          accept;

  // Sign-extend the coordinates from their live width
  assign x_sh  = x_coord << SH;
  assign y_sh  = y_value << SH;
  assign x_ext = x_sh >>> SH;
  assign y_ext = y_sh >>> SH;

  assign dx_prev    = {x_ext[COORD_MAX_W-1], x_ext} - {prev_x[COORD_MAX_W-1], prev_x};
  assign dx_anchor  = {x_ext[COORD_MAX_W-1], x_ext} - {anchor_x[COORD_MAX_W-1], anchor_x};
  assign y_w        = {{(FAC_W - COORD_MAX_W){y_ext[COORD_MAX_W-1]}}, y_ext};
  assign prev_y_w   = {{(FAC_W - COORD_MAX_W){prev_y[COORD_MAX_W-1]}}, prev_y};
  assign anchor_y_w = {{(FAC_W - COORD_MAX_W){anchor_y[COORD_MAX_W-1]}}, anchor_y};

  assign accept = in_valid && !q_full;
  assign q_push = accept;

  // Classify the point and form its term operands
  always_comb begin
    q_op       = '0;
    q_op.kind  = KIND_PLAIN;
    q_op.last  = last_point;
    phase_next = PH_ANCHOR;
    set_anchor = 1'b1;
    if (rule_mode[1]) begin
      case (phase)
        PH_MID: begin
          q_op.dx   = dx_anchor;
          q_op.fac  = anchor_y_w + (prev_y_w <<< 2) + y_w;
          q_op.kind = KIND_SIXTH;
        end
        PH_ANCHOR: begin
          phase_next = PH_MID;
          set_anchor = 1'b0;
        end
        default: begin
        end
      endcase
    end else if (phase != PH_IDLE) begin
      q_op.dx = dx_prev;
      if (rule_mode == MODE_RECT) begin
        q_op.fac = prev_y_w;
      end else begin
        q_op.fac  = prev_y_w + y_w;
        q_op.kind = KIND_HALF;
      end
    end
    if (last_point) begin
      phase_next = PH_IDLE;
    end
  end

  // Hold rule and curve phase
  always_ff @(posedge clk) begin
    if (rst) begin
      rule_mode <= RULE_RESET;
      phase     <= PH_IDLE;
    end else begin
      if (rule_we) begin
        rule_mode <= rule_wdata;
      end
      if (accept) begin
        phase <= phase_next;
      end
    end
  end

  // Keep the newest point and the open Simpson anchor
  always_ff @(posedge clk) begin
    if (accept) begin
      prev_x <= x_ext;
      prev_y <= y_ext;
      if (set_anchor) begin
        anchor_x <= x_ext;
        anchor_y <= y_ext;
      end
    end
  end

  // A closed curve leaves no point pending
  a_last_clears_phase: assert property (@(posedge clk) disable iff (rst)
    (accept && last_point) |=> (phase == PH_IDLE))
    else $error("phase not cleared after last point");

endmodule
`default_nettype wire

@@ hw/rtl/scai_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scai_back: term datapath and accumulator
// Multiplies width by ordinate sum in two partial products, halves or
// divides by six a chunk per stage, clamps the term and adds it into the
// saturating area register. Delivers a result beat on the last point.
// ----------------------------------------------------------------------------
module scai_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          q_empty,
  input  wire scai_pkg::op_t q_op,
  output logic               q_pop,
  input  wire logic          res_full,
  output logic               res_push,
  output scai_pkg::result_t  res
);

  import scai_pkg::*;

  localparam int MDX_W   = DX_W - 1;
  localparam int MFAC_W  = FAC_W - 1;
  localparam int CHUNK_W = 17;
  localparam int NCHUNK  = 4;
  localparam int PROD_W  = CHUNK_W * NCHUNK;
  localparam int PP_W    = MDX_W + CHUNK_W;
  localparam int T_W     = CHUNK_W + 3;
  localparam logic [T_W-1:0] DIV6_MUL = 20'd699051;
  localparam int DIV6_SH = 22;
  localparam logic [PROD_W-1:0] POS_LIM = {{(PROD_W - AREA_W + 1){1'b0}},
                                           {(AREA_W - 1){1'b1}}};
  localparam logic [PROD_W-1:0] NEG_LIM = POS_LIM + 1'b1;
  localparam logic [AREA_W-1:0] AREA_MAX = {1'b0, {(AREA_W - 1){1'b1}}};
  localparam logic [AREA_W-1:0] AREA_MIN = {1'b1, {(AREA_W - 1){1'b0}}};

  typedef struct packed {
    logic  neg;
    kind_t kind;
    logic  last;
  } ctl_t;

  // One long-division digit by six: returns {remainder, quotient}
  function automatic logic [T_W-1:0] div6_step(input logic [T_W-1:0] t);
    logic [2*T_W-1:0]   p;
    logic [CHUNK_W-1:0] q;
    logic [T_W-1:0]     rr;
    p  = t * DIV6_MUL;
    q  = p[DIV6_SH +: CHUNK_W];
    rr = t - ({3'b0, q} * T_W'(6));
    return {rr[2:0], q};
  endfunction

  logic en;

  // Stage 1: magnitudes and sign
  logic              v1;
  ctl_t              c1;
  logic [MDX_W-1:0]  mag_dx;
  logic [MFAC_W-1:0] mag_fac;
  logic [DX_W-1:0]   dx_abs;
  logic [FAC_W-1:0]  fac_abs;
  // Stage 2: partial products
  logic              v2;
  ctl_t              c2;
  logic [PP_W-1:0]   pp_lo;
  logic [PP_W-1:0]   pp_hi;
  // Stage 3: full product magnitude
  logic              v3;
  ctl_t              c3;
  logic [PROD_W-1:0] prod;
  // Division stages
  logic              vd   [NCHUNK];
  ctl_t              cd   [NCHUNK];
  logic [PROD_W-1:0] dnum [NCHUNK];
  logic [2:0]        drem [NCHUNK];
  logic [PROD_W-1:0] adj  [NCHUNK];
  logic [PROD_W-1:0] dnum_next [NCHUNK];
  logic [2:0]        drem_next [NCHUNK];
  // Clamp stage
  logic              vc;
  ctl_t              cc;
  logic [AREA_W-1:0] term;
  logic              term_ovf;
  logic [PROD_W-1:0] mag_sel;
  logic [AREA_W-1:0] term_next;
  logic              term_ovf_next;
  // Accumulator
  logic [AREA_W-1:0] run_area;
  logic              ovf_seen;
  logic [AREA_W-1:0] sum;
  logic              sum_sat;
  logic [AREA_W-1:0] area_next;
  logic              ovf_next;

  // Stall only when a finished curve cannot be delivered
  assign en       = !(vc && cc.last && res_full);
  assign q_pop    = en && !q_empty;
  assign res_push = en && vc && cc.last;

  assign dx_abs  = q_op.dx[DX_W-1] ? DX_W'(-q_op.dx) : DX_W'(q_op.dx);
  assign fac_abs = q_op.fac[FAC_W-1] ? FAC_W'(-q_op.fac) : FAC_W'(q_op.fac);

  // Work one quotient chunk per stage, most significant first
  always_comb begin
    logic [PROD_W-1:0] num_in;
    logic [2:0]        rem_in;
    logic [T_W-1:0]    step;
    for (int i = 0; i < NCHUNK; i++) begin
      num_in = (i == 0) ? prod : dnum[(i == 0) ? 0 : i - 1];
      rem_in = (i == 0) ? 3'd0 : drem[(i == 0) ? 0 : i - 1];
      step   = div6_step({rem_in, num_in[(NCHUNK - 1 - i) * CHUNK_W +: CHUNK_W]});
      dnum_next[i] = num_in;
      dnum_next[i][(NCHUNK - 1 - i) * CHUNK_W +: CHUNK_W] = step[CHUNK_W-1:0];
      drem_next[i] = step[T_W-1 -: 3];
    end
  end

  // Clamp the term to the area range
  always_comb begin
    mag_sel       = (cd[NCHUNK-1].kind == KIND_SIXTH) ? dnum[NCHUNK-1] : adj[NCHUNK-1];
    term_ovf_next = 1'b0;
    if (cd[NCHUNK-1].neg) begin
      if (mag_sel > NEG_LIM) begin
        term_next     = AREA_MIN;
        term_ovf_next = 1'b1;
      end else begin
        term_next = AREA_W'(-mag_sel);
      end
    end else begin
      if (mag_sel > POS_LIM) begin
        term_next     = AREA_MAX;
        term_ovf_next = 1'b1;
      end else begin
        term_next = mag_sel[AREA_W-1:0];
      end
    end
  end

  // Saturating add into the running area
  always_comb begin
    sum       = run_area + term;
    sum_sat   = (run_area[AREA_W-1] == term[AREA_W-1]) &&
                (sum[AREA_W-1] != run_area[AREA_W-1]);
    area_next = sum_sat ? (run_area[AREA_W-1] ? AREA_MIN : AREA_MAX) : sum;
    ovf_next  = ovf_seen || term_ovf || sum_sat;
  end

  assign res.area      = area_next;
  assign res.saturated = ovf_next;

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vc <= 1'b0;
      for (int i = 0; i < NCHUNK; i++) begin
        vd[i] <= 1'b0;
      end
    end else if (en) begin
      v1 <= !q_empty;
      v2 <= v1;
      v3 <= v2;
      vd[0] <= v3;
      for (int i = 1; i < NCHUNK; i++) begin
        vd[i] <= vd[i-1];
      end
      vc <= vd[NCHUNK-1];
    end
  end

  // Advance stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      c1.neg  <= q_op.dx[DX_W-1] ^ q_op.fac[FAC_W-1];
      c1.kind <= q_op.kind;
      c1.last <= q_op.last;
      mag_dx  <= dx_abs[MDX_W-1:0];
      mag_fac <= fac_abs[MFAC_W-1:0];

      c2    <= c1;
      pp_lo <= mag_dx * mag_fac[CHUNK_W-1:0];
      pp_hi <= mag_dx * mag_fac[MFAC_W-1:CHUNK_W];

      c3   <= c2;
      prod <= PROD_W'(pp_lo) + (PROD_W'(pp_hi) << CHUNK_W);

      cd[0]  <= c3;
      adj[0] <= (c3.kind == KIND_HALF) ? ((prod + PROD_W'(c3.neg)) >> 1) : prod;
      for (int i = 1; i < NCHUNK; i++) begin
        cd[i]  <= cd[i-1];
        adj[i] <= adj[i-1];
      end
      for (int i = 0; i < NCHUNK; i++) begin
        dnum[i] <= dnum_next[i];
        drem[i] <= drem_next[i];
      end

      cc       <= cd[NCHUNK-1];
      term     <= term_next;
      term_ovf <= term_ovf_next;
    end
  end

  // Update the running area; clear it once a curve is delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      run_area <= '0;
      ovf_seen <= 1'b0;
    end else if (en && vc) begin
      if (cc.last) begin
        run_area <= '0;
        ovf_seen <= 1'b0;
      end else begin
        run_area <= area_next;
        ovf_seen <= ovf_next;
      end
    end
  end

  // No result beat is lost to a full output queue
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into full queue");

  // A stalled term waits unchanged in the clamp stage
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (vc && !en) |=> (vc && $stable(term) && $stable(term_ovf)))
    else $error("stalled term changed");

  // A delivered curve restarts the area from zero
  a_curve_restart: assert property (@(posedge clk) disable iff (rst)
    res_push |=> (run_area == '0 && !ovf_seen))
    else $error("area not cleared after result");

endmodule
`default_nettype wire

@@ hw/rtl/sample_curve_area_integrator.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sample_curve_area_integrator: streaming area under a sampled curve
// Integrates Q16.16 points by left rectangle, trapezoid or Simpson rule into
// a saturating Q32.32 area and delivers one result per curve.
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload                          direction
//  -------   ----------------   ------------------------------   ---------
//  points    push / full        x_coord, y_value, last_point     in
//  results   pop / empty        area, saturated                  out
//  config    cfg_we             cfg_wdata (rule_mode)            in
//
//  One point beat is taken every cycle while full is low; the rate is set by
//  the single term datapath, which starts one product per cycle unless a
//  finished result cannot be delivered. A curve's result passes through the
//  eight multiply, divide and clamp stages, the first loaded as the beat
//  leaves the operation queue, and is then pushed into the result queue.
//  Reset leaves the rule at trapezoid, no clearing pass. A stall on pop
//  halts the term datapath only when a finished result waits on a full
//  result queue; the 4-beat operation queue then fills before full rises.
//
module sample_curve_area_integrator #(
  parameter int COORD_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [31:0] x_coord,
  input  wire logic [31:0] y_value,
  input  wire logic        last_point,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_wdata,
  output logic             empty,
  input  wire logic        pop,
  output logic [63:0]      area,
  output logic             saturated
);

  import scai_pkg::*;

  localparam int OPQ_DEPTH = 4;
  localparam int RESQ_DEPTH = 2;

  op_t     fr_op;
  logic    fr_push;
  op_t     bk_op;
  logic    bk_pop;
  logic    opq_empty;
  result_t bk_res;
  logic    bk_push;
  logic    resq_full;
  result_t out_res;

  // Classify points
  scai_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .rule_we    (cfg_we),
    .rule_wdata (cfg_wdata),
    .in_valid   (push),
    .x_coord    (x_coord),
    .y_value    (y_value),
    .last_point (last_point),
    .q_full     (full),
    .q_push     (fr_push),
    .q_op       (fr_op)
  );

  // Decouple classifier from datapath
  scai_fifo #(
    .WIDTH ($bits(op_t)),
    .DEPTH (OPQ_DEPTH)
  ) u_opq (
    .clk   (clk),
    .rst   (rst),
    .push  (fr_push),
    .wdata (fr_op),
    .full  (full),
    .pop   (bk_pop),
    .rdata (bk_op),
    .empty (opq_empty)
  );

  // Evaluate and accumulate terms
  scai_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (opq_empty),
    .q_op     (bk_op),
    .q_pop    (bk_pop),
    .res_full (resq_full),
    .res_push (bk_push),
    .res      (bk_res)
  );

  // Hold finished results for the consumer
  scai_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (RESQ_DEPTH)
  ) u_resq (
    .clk   (clk),
    .rst   (rst),
    .push  (bk_push),
    .wdata (bk_res),
    .full  (resq_full),
    .pop   (pop),
    .rdata (out_res),
    .empty (empty)
  );

  assign area      = out_res.area;
  assign saturated = out_res.saturated;

endmodule
`default_nettype wire
